### design/arw_pkg.sv
// arw_pkg: shared types and constants for the anti-replay window
// no dependencies
`default_nettype none

package arw_pkg;

   localparam int COUNTER_W = 64;
   localparam int WORD_W    = 64;

   typedef enum logic [1:0] {
      VERDICT_ADVANCED  = 2'd0,
      VERDICT_INSIDE    = 2'd1,
      VERDICT_DUPLICATE = 2'd2,
      VERDICT_BELOW     = 2'd3
   } verdict_type;

endpackage

`default_nettype wire

### design/anti_replay_window.sv
// anti_replay_window: sliding-window replay check on 64-bit datagram counters
// depends on arw_pkg
//
// One counter per transfer on req_, one verdict per counter on rsp_, in order.
// The block takes a new counter every cycle while rsp_ready is high. Each
// result is loaded into the result register from the input register:
// the compare, barrel shift and bit test of the window bitmap run while
// the counter sits in the input register, and the top counter and
// bitmap are updated as the result register is loaded. A stalled result
// holds the input register, and req_ready then drops.
// The bitmap holds (WINDOW_BITS/64)*64 bits; bit b stands for top - b.
// Both the top counter and the bitmap are cleared by reset, as is the input
// register's valid flag, so the block accepts counters as soon as reset ends.
`default_nettype none

module anti_replay_window #(
   parameter int WINDOW_BITS = 1024
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [arw_pkg::COUNTER_W-1:0]   req_counter,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_is_new,
   output logic [1:0]                           rsp_verdict
);

   localparam int MAP_BITS = (WINDOW_BITS / arw_pkg::WORD_W) * arw_pkg::WORD_W;
   localparam int IDX_W    = $clog2(MAP_BITS);
   localparam logic [arw_pkg::COUNTER_W-1:0] MAP_LIMIT = arw_pkg::COUNTER_W'(MAP_BITS);

   logic                            in_valid_ff, in_valid_in;
   logic [arw_pkg::COUNTER_W-1:0]   in_counter_ff;
   logic                            out_valid_ff, out_valid_in;
   logic                            out_is_new_ff, out_is_new_in;
   arw_pkg::verdict_type            out_verdict_ff, out_verdict_in;
   logic [arw_pkg::COUNTER_W-1:0]   top_ff, top_in;
   logic [MAP_BITS-1:0]             map_ff, map_in;

   logic                            fire;
   logic                            take;
   logic                            above;
   logic [arw_pkg::COUNTER_W-1:0]   jump;
   logic [arw_pkg::COUNTER_W-1:0]   behind;
   logic [IDX_W-1:0]                bit_idx;
   logic [MAP_BITS-1:0]             slid;
   logic [MAP_BITS-1:0]             one_hot;

   // handshake
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign take      = req_valid && req_ready;

   assign in_valid_in  = take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_ready);

   // window check
   assign above   = in_counter_ff > top_ff;
   assign jump    = in_counter_ff - top_ff;
   assign behind  = top_ff - in_counter_ff;
   assign bit_idx = behind[IDX_W-1:0];
   assign one_hot = {{(MAP_BITS-1){1'b0}}, 1'b1} << bit_idx;

   always_comb begin
      if (jump < MAP_LIMIT) begin
         slid = map_ff << jump[IDX_W-1:0];
      end else begin
         slid = '0;
      end
   end

   always_comb begin
      top_in         = top_ff;
      map_in         = map_ff;
      out_is_new_in  = out_is_new_ff;
      out_verdict_in = out_verdict_ff;
      if (fire) begin
         priority if (above) begin
            top_in         = in_counter_ff;
            map_in         = slid | {{(MAP_BITS-1){1'b0}}, 1'b1};
            out_is_new_in  = 1'b1;
            out_verdict_in = arw_pkg::VERDICT_ADVANCED;
         end else if (behind >= MAP_LIMIT) begin
            out_is_new_in  = 1'b0;
            out_verdict_in = arw_pkg::VERDICT_BELOW;
         end else if (map_ff[bit_idx]) begin
            out_is_new_in  = 1'b0;
            out_verdict_in = arw_pkg::VERDICT_DUPLICATE;
         end else begin
            map_in         = map_ff | one_hot;
            out_is_new_in  = 1'b1;
            out_verdict_in = arw_pkg::VERDICT_INSIDE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         top_ff       <= '0;
         map_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         top_ff       <= top_in;
         map_ff       <= map_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (take) begin
         in_counter_ff <= req_counter;
      end
      out_is_new_ff  <= out_is_new_in;
      out_verdict_ff <= out_verdict_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_is_new  = out_is_new_ff;
   assign rsp_verdict = out_verdict_ff;

endmodule

`default_nettype wire

### tb/sv/anti_replay_window_tb.sv
`timescale 1ns / 100ps
// anti_replay_window_tb: self-checking bench for the anti-replay window block
// depends on arw_pkg and anti_replay_window; the window predictor and verdict
// tracker are a class inside this module, stimulus and the request handshake are plain tasks

module anti_replay_window_tb;

   localparam int WIN = 1024;
   localparam int SEGMENTS = 13;
   localparam int SEG_ITEMS = 148;
   localparam bit [63:0] MAX_COUNTER = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [63:0]          counter;
      logic                 is_new;
      arw_pkg::verdict_type verdict;
   } verdict_rec;

   class replay_tracker;
      bit [63:0]    top;
      bit [WIN-1:0] seen;
      verdict_rec   verdicts_due[$];
      int           errors;
      int           tally[4];

      function void note_counter(bit [63:0] c);
         verdict_rec rec;
         bit [63:0] behind;
         rec.counter = c;
         if (c > top) begin
            if (c - top >= WIN)
               seen = '0;
            else
               seen = seen << (c - top);
            top = c;
            seen[0] = 1'b1;
            rec.is_new = 1'b1;
            rec.verdict = arw_pkg::VERDICT_ADVANCED;
         end else begin
            behind = top - c;
            if (behind >= WIN) begin
               rec.is_new = 1'b0;
               rec.verdict = arw_pkg::VERDICT_BELOW;
            end else if (seen[behind]) begin
               rec.is_new = 1'b0;
               rec.verdict = arw_pkg::VERDICT_DUPLICATE;
            end else begin
               seen[behind] = 1'b1;
               rec.is_new = 1'b1;
               rec.verdict = arw_pkg::VERDICT_INSIDE;
            end
         end
         tally[rec.verdict]++;
         verdicts_due.push_back(rec);
      endfunction

      function void check_verdict(logic is_new, logic [1:0] verdict);
         verdict_rec rec;
         if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected result transfer: is_new %b verdict %b",
                     $time, is_new, verdict);
            errors++;
            return;
         end
         rec = verdicts_due.pop_front();
         if (is_new !== rec.is_new) begin
            $display("%0t: counter %h is_new: expected %0b, actual %b",
                     $time, rec.counter, rec.is_new, is_new);
            errors++;
         end
         if (verdict !== rec.verdict) begin
            $display("%0t: counter %h verdict: expected %0d, actual %b",
                     $time, rec.counter, rec.verdict, verdict);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_counter;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_is_new;
   logic [1:0]  rsp_verdict;

   replay_tracker tracker;
   bit [63:0]     sent_top;
   bit [63:0]     recent[$];
   int            send_idle_pct;
   int            recv_idle_pct;

   anti_replay_window #(.WINDOW_BITS(WIN)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_counter (req_counter),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_is_new  (rsp_is_new),
      .rsp_verdict (rsp_verdict)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout, %0d results still due", $time, tracker.verdicts_due.size());
      $display("** anti_replay_window: FAILED **");
      $finish;
   end

   // both channels observed at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.note_counter(req_counter);
         if (rsp_valid && rsp_ready)
            tracker.check_verdict(rsp_is_new, rsp_verdict);
      end
   end

   // result side back-pressure in bursts
   initial begin
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            n = $urandom_range(1, 5);
            rsp_ready <= 1'b0;
            repeat (n - 1) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
            end
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic bit [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic bit [63:0] above_top(bit [63:0] d);
      return (sent_top > MAX_COUNTER - d) ? MAX_COUNTER : sent_top + d;
   endfunction

   function automatic bit [63:0] under_top(bit [63:0] d);
      return (sent_top < d) ? 64'd0 : sent_top - d;
   endfunction

   task automatic send_counter(input bit [63:0] value);
      int gap;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 5);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_counter <= value;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (value > sent_top)
         sent_top = value;
      recent.push_back(value);
      if (recent.size() > 64)
         void'(recent.pop_front());
   endtask

   // mostly well-formed traffic around the current top, some stale noise
   function automatic bit [63:0] pick_counter();
      int r;
      bit [63:0] d;
      r = $urandom_range(0, 99);
      if (r < 30)
         return above_top($urandom_range(1, 70));
      if (r < 38)
         return above_top($urandom_range(70, WIN - 1));
      if (r < 41) begin
         d = ($urandom_range(0, 3) == 0) ? WIN : $urandom_range(WIN, 3 * WIN);
         return above_top(d);
      end
      if (r < 71) begin
         d = ($urandom_range(0, 7) == 0) ? WIN - 1 : $urandom_range(0, WIN - 1);
         return under_top(d);
      end
      if (r < 86 && recent.size() != 0)
         return recent[$urandom_range(0, recent.size() - 1)];
      if (r < 94) begin
         d = ($urandom_range(0, 3) == 0) ? WIN : WIN + $urandom_range(0, 5000);
         return under_top(d);
      end
      if (sent_top == MAX_COUNTER)
         return rand64();
      return rand64() % (sent_top + 1);
   endfunction

   initial begin
      bit [63:0] directed[22] = '{
         64'd0, 64'd0, 64'd1, 64'd1, 64'd5, 64'd3, 64'd3, 64'd2, 64'd0,
         64'd1028, 64'd5, 64'd4, 64'd2052, 64'd1028, 64'd1029, 64'd1029,
         64'd2116, 64'd2052, 64'd2117, 64'd2053, 64'd1094, 64'd1093
      };
      tracker = new();
      sent_top = '0;
      send_idle_pct = 30;
      recv_idle_pct = 30;
      reset = 1'b1;
      req_valid = 1'b0;
      req_counter = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_counter(directed[i]);

      for (int k = 0; k < SEGMENTS; k++) begin
         if (k >= SEGMENTS - 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = (k % 3 == 0) ? 0 : (k % 3 == 1) ? 30 : 60;
            recv_idle_pct = (k % 3 == 0) ? 40 : (k % 3 == 1) ? 0 : 20;
         end
         // each stretch starts with a jump to a higher region of the counter space
         if (k == SEGMENTS - 1)
            send_counter(MAX_COUNTER - $urandom_range(WIN, 4 * WIN));
         else
            send_counter(above_top(WIN + (rand64() >> (54 - 4 * k))));
         repeat (SEG_ITEMS - 1)
            send_counter(pick_counter());
      end

      // top of the counter space
      send_counter(MAX_COUNTER);
      send_counter(MAX_COUNTER);
      send_counter(64'd0);
      send_counter(MAX_COUNTER - 1023);
      send_counter(MAX_COUNTER - 1024);
      send_counter(MAX_COUNTER - 1);

      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.verdicts_due.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("checked %0d advances, %0d new in window, %0d duplicates, %0d too old",
               tracker.tally[arw_pkg::VERDICT_ADVANCED],
               tracker.tally[arw_pkg::VERDICT_INSIDE],
               tracker.tally[arw_pkg::VERDICT_DUPLICATE],
               tracker.tally[arw_pkg::VERDICT_BELOW]);
      $display("final window top %h, %0d mismatches", tracker.top, tracker.errors);
      if (tracker.errors == 0)
         $display("** anti_replay_window: PASSED **");
      else
         $display("** anti_replay_window: FAILED **");
      $finish;
   end

endmodule
